// File: rtl/leashed_position_follower_unit_assert.svh
// Assertion macros shared by the block's modules.
`ifndef LEASHED_POSITION_FOLLOWER_UNIT_ASSERT_SVH
`define LEASHED_POSITION_FOLLOWER_UNIT_ASSERT_SVH

// An implication that is checked on every clock edge outside reset.
`define LPF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// An implication whose consequence is checked in the cycle after the antecedent.
`define LPF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/lpf_pkg.sv
package lpf_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned PosW = 32;
  localparam int unsigned CfgW = 31;
  localparam int unsigned DtW = 17;

  localparam logic CfgIdxSpeed = 1'b0;
  localparam logic CfgIdxMaxDist = 1'b1;

  localparam logic ModeFollow = 1'b0;
  localparam logic ModeTeleport = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQR,
    ST_SQRT,
    ST_LEASH,
    ST_ALPHA,
    ST_MOVE,
    ST_OUT
  } lpf_state_t;

  typedef struct packed {
    logic start;
    logic [63:0] num;
    logic [63:0] den;
  } lpf_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lpf_div_stat_t;

  function automatic logic [PosW-1:0] sat32(input logic signed [PosW+1:0] v);
    logic signed [PosW+1:0] hi;
    logic signed [PosW+1:0] lo;
    hi = (PosW+2)'(signed'(33'sh0_7FFF_FFFF));
    lo = -(PosW+2)'(signed'(33'sh0_8000_0000));
    if (v > hi) begin
      return {1'b0, {(PosW-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(PosW-1){1'b0}}};
    end
    return v[PosW-1:0];
  endfunction

endpackage

// File: rtl/lpf_if.sv
interface lpf_in_if;
  logic mode;
  logic [31:0] target_x;
  logic [31:0] target_y;
  logic [31:0] target_z;
  logic [16:0] delta_time;
  logic valid;
  logic ready;
  modport source(output mode, target_x, target_y, target_z, delta_time, valid, input ready);
  modport sink(input mode, target_x, target_y, target_z, delta_time, valid, output ready);
endinterface

interface lpf_out_if;
  logic [31:0] lag_x;
  logic [31:0] lag_y;
  logic [31:0] lag_z;
  logic valid;
  logic ready;
  modport source(output lag_x, lag_y, lag_z, valid, input ready);
  modport sink(input lag_x, lag_y, lag_z, valid, output ready);
endinterface

// File: rtl/lpf_divider.sv
module lpf_divider (
  input  logic clk,
  input  logic rst_n,
  input  lpf_pkg::lpf_div_req_t req,
  output lpf_pkg::lpf_div_stat_t stat,
  output logic [63:0] quot
);
  import lpf_pkg::*;

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] den_r, den_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [64:0] trial;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r, quo_r[63]} - {1'b0, den_r};
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = req.num;
      den_nxt = req.den;
      cnt_nxt = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[62:0], quo_r[63]};
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot = quo_r;

`include "leashed_position_follower_unit_assert.svh"
  `LPF_ASSERT_NEXT(a_div_done, busy_r && cnt_r == 7'd1 && !req.start, done_r)
  `LPF_ASSERT_IMP(a_div_cnt, busy_r, cnt_r != 7'd0)
  `LPF_ASSERT_NEXT(a_div_start, req.start, busy_r)
endmodule

// File: rtl/leashed_position_follower_unit.sv
// Leashed position follower: a 3D point that trails a target position.
// Input channel in_*: one request carries mode, a target point and a time
// step. Output channel out_*: one result per request, the new lagging point.
// Config port cfg_*: index 0 writes lag_speed, index 1 writes max_dist; the
// user must write it only while the block is idle; the block does not enforce it.
// A follow request computes the distance with a bit-serial square root, then
// uses one shared 64-step restoring divider for the three leash quotients and
// for alpha, and one shared multiplier for squares and products, one per cycle.
// The leash step runs only when the distance exceeds max_dist. A teleport
// request goes from idle straight to the output state, where the result is
// registered. in_ready is low from acceptance until the result is taken.
// Reset clears the lagging point and both registers to zero.
// If the receiver stalls, the result holds on out_* until out_ready.
module leashed_position_follower_unit #(
  parameter int unsigned FRAC_BITS = lpf_pkg::FracBitsDefault
) (
  input  logic clk,
  input  logic rst_n,
  lpf_in_if.sink in_ch,
  lpf_out_if.source out_ch,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [lpf_pkg::CfgW-1:0] cfg_data
);
  import lpf_pkg::*;

  lpf_state_t state_r, state_nxt;
  logic [CfgW-1:0] speed_r, maxd_r;
  logic signed [PosW-1:0] fol_r [3];
  logic signed [PosW-1:0] tgt_r [3];
  logic [32:0] mag_r [3];
  logic neg_r [3];
  logic sh_r;
  logic [63:0] sum_r;
  logic [16:0] dt_r;
  logic [1:0] ax_r;
  logic [5:0] it_r;
  logic [63:0] sq_v_r, sq_b_r;
  logic [63:0] sq_r_r;
  logic [32:0] dist_r;
  logic [32:0] lagd_r;
  logic [FRAC_BITS:0] alpha_r;
  logic divwait_r;
  logic outv_r;
  logic [PosW-1:0] out_r [3];

  logic [63:0] mul_a, mul_b, mul_p;
  lpf_div_req_t dreq;
  lpf_div_stat_t dstat;
  logic [63:0] dq;
  logic [64:0] sq_t;
  logic [32:0] root_d;
  logic [32:0] ax_d;
  logic [32:0] msh;
  logic signed [PosW+1:0] newpos;
  logic [32:0] qcl;
  logic [63:0] amax;

  assign mul_p = mul_a[31:0] * mul_b[31:0] + (mul_a[32] ? {mul_b[31:0], 32'd0} : 64'd0);
  assign amax = 64'd1 << FRAC_BITS;

  lpf_divider u_div (
    .clk(clk), .rst_n(rst_n), .req(dreq), .stat(dstat), .quot(dq)
  );

  always_comb begin
    state_nxt = state_r;
    mul_a = '0;
    mul_b = '0;
    dreq = '0;
    ax_d = 33'(signed'(tgt_r[ax_r])) - 33'(signed'(fol_r[ax_r]));
    msh = mag_r[ax_r] >> sh_r;
    sq_t = {1'b0, sq_v_r} - {1'b0, (sq_r_r + sq_b_r)};
    root_d = {1'b0, sq_r_r[31:0]} << sh_r;
    qcl = (dq > {31'd0, mag_r[ax_r]}) ? mag_r[ax_r] : dq[32:0];
    newpos = '0;
    case (state_r)
      ST_SQR: begin
        mul_a = {31'd0, msh};
        mul_b = {31'd0, msh};
      end
      ST_LEASH: begin
        mul_a = {31'd0, mag_r[ax_r]};
        mul_b = {33'd0, maxd_r};
      end
      ST_ALPHA: begin
        mul_a = {33'd0, speed_r};
        mul_b = {47'd0, dt_r};
      end
      ST_MOVE: begin
        mul_a = {31'd0, mag_r[ax_r]};
        mul_b = {{(63-FRAC_BITS){1'b0}}, alpha_r};
      end
      default: begin
      end
    endcase
    case (state_r)
      ST_IDLE: if (in_ch.valid && !outv_r) state_nxt = (in_ch.mode == ModeTeleport) ? ST_OUT : ST_DIFF;
      ST_DIFF: if (ax_r == 2'd2) state_nxt = ST_SQR;
      ST_SQR: if (ax_r == 2'd2) state_nxt = ST_SQRT;
      ST_SQRT: if (it_r == 6'd32) state_nxt = (root_d > {2'd0, maxd_r}) ? ST_LEASH : ST_ALPHA;
      ST_LEASH: if (dstat.done && ax_r == 2'd2) state_nxt = ST_ALPHA;
      ST_ALPHA: if (lagd_r == 33'd0 || (dstat.done)) state_nxt = ST_MOVE;
      ST_MOVE: if (ax_r == 2'd2) state_nxt = ST_OUT;
      ST_OUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_LEASH && !divwait_r) begin
      dreq.start = 1'b1;
      dreq.num = mul_p;
      dreq.den = {31'd0, dist_r};
    end
    if (state_r == ST_ALPHA && !divwait_r && lagd_r != 33'd0) begin
      dreq.start = 1'b1;
      dreq.num = mul_p;
      dreq.den = {31'd0, lagd_r};
    end
    if (state_r == ST_MOVE) begin
      newpos = neg_r[ax_r] ? 34'(signed'(fol_r[ax_r])) - 34'(mul_p >> FRAC_BITS)
                           : 34'(signed'(fol_r[ax_r])) + 34'(mul_p >> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      speed_r <= '0;
      maxd_r <= '0;
      fol_r <= '{default: '0};
      outv_r <= 1'b0;
      divwait_r <= 1'b0;
      ax_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == CfgIdxSpeed) speed_r <= cfg_data;
        else maxd_r <= cfg_data;
      end
      if (out_ch.valid && out_ch.ready) outv_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          ax_r <= '0;
          if (in_ch.valid && !outv_r) begin
            tgt_r[0] <= in_ch.target_x;
            tgt_r[1] <= in_ch.target_y;
            tgt_r[2] <= in_ch.target_z;
            dt_r <= in_ch.delta_time;
            sh_r <= 1'b0;
            sum_r <= '0;
            if (in_ch.mode == ModeTeleport) begin
              fol_r[0] <= in_ch.target_x;
              fol_r[1] <= in_ch.target_y;
              fol_r[2] <= in_ch.target_z;
            end
          end
        end
        ST_DIFF: begin
          neg_r[ax_r] <= ax_d[32];
          mag_r[ax_r] <= ax_d[32] ? -ax_d : ax_d;
          if ((ax_d[32] ? -ax_d : ax_d) > 33'h0_8000_0000) sh_r <= 1'b1;
          ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
        end
        ST_SQR: begin
          sum_r <= sum_r + mul_p;
          ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
          it_r <= '0;
          if (ax_r == 2'd2) begin
            sq_v_r <= sum_r + mul_p;
            sq_b_r <= 64'd1 << 62;
            sq_r_r <= '0;
          end
        end
        ST_SQRT: begin
          if (it_r != 6'd32) begin
            if (!sq_t[64]) begin
              sq_v_r <= sq_t[63:0];
              sq_r_r <= (sq_r_r >> 1) + sq_b_r;
            end else begin
              sq_r_r <= sq_r_r >> 1;
            end
            sq_b_r <= sq_b_r >> 2;
            it_r <= it_r + 6'd1;
          end else begin
            dist_r <= root_d;
            lagd_r <= (root_d > {2'd0, maxd_r}) ? {2'd0, maxd_r} : root_d;
          end
        end
        ST_LEASH: begin
          if (!divwait_r) divwait_r <= 1'b1;
          else if (dstat.done) begin
            divwait_r <= 1'b0;
            mag_r[ax_r] <= qcl;
            fol_r[ax_r] <= neg_r[ax_r] ? 32'(tgt_r[ax_r] + signed'(qcl))
                                       : 32'(tgt_r[ax_r] - signed'(qcl));
            ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
          end
        end
        ST_ALPHA: begin
          if (lagd_r == 33'd0) alpha_r <= amax[FRAC_BITS:0];
          else if (!divwait_r) divwait_r <= 1'b1;
          else if (dstat.done) begin
            divwait_r <= 1'b0;
            alpha_r <= (dq > amax) ? amax[FRAC_BITS:0] : dq[FRAC_BITS:0];
          end
        end
        ST_MOVE: begin
          fol_r[ax_r] <= sat32(newpos);
          ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
        end
        ST_OUT: begin
          out_r[0] <= fol_r[0];
          out_r[1] <= fol_r[1];
          out_r[2] <= fol_r[2];
          outv_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE) && !outv_r;
  assign out_ch.valid = outv_r;
  assign out_ch.lag_x = out_r[0];
  assign out_ch.lag_y = out_r[1];
  assign out_ch.lag_z = out_r[2];

`include "leashed_position_follower_unit_assert.svh"
  `LPF_ASSERT_IMP(a_rdy_idle, in_ch.ready, state_r == ST_IDLE)
  `LPF_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.lag_x))
  `LPF_ASSERT_IMP(a_no_rdy_busy, out_ch.valid, !in_ch.ready)
  `LPF_ASSERT_IMP(a_alpha_max, state_r == ST_MOVE, alpha_r <= amax[FRAC_BITS:0])
endmodule
